// ===== design/cds_pkg.sv =====
// Shared types and constants for the C-LOOK disk scheduler.
// No dependencies.
package cds_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_REQUESTS_DEF = 32;
    localparam int TRACK_BITS_DEF   = 16;

    // Fixed field widths
    localparam int FIELD_W  = 16;
    localparam int TOTAL_W  = 21;
    localparam int TSEEK_W  = 37;
    localparam int AVG_W    = 32;

    localparam logic [FIELD_W-1:0] SEEK_RESET = 16'd1;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // Command handed from the front queue to the back end
    typedef struct packed {
        logic               is_run;
        logic [FIELD_W-1:0] track;
        logic [FIELD_W-1:0] head_track;
        logic               sweep_up;
    } t_cmd;

endpackage

// ===== design/cds_ifs.sv =====
// Channel interfaces of the C-LOOK disk scheduler: request, result, config.
// Depends on cds_pkg.
interface cds_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [cds_pkg::FIELD_W-1:0]   track;
    logic [cds_pkg::FIELD_W-1:0]   head_track;
    logic                          sweep_up;
    modport source (output valid, func, track, head_track, sweep_up, input ready);
    modport sink   (input valid, func, track, head_track, sweep_up, output ready);
endinterface

interface cds_res_if;
    logic                          valid;
    logic                          ready;
    logic [cds_pkg::FIELD_W-1:0]   seek_track;
    logic                          is_last;
    logic [cds_pkg::TOTAL_W-1:0]   total_tracks;
    logic [cds_pkg::TSEEK_W-1:0]   total_seek_time;
    logic [cds_pkg::AVG_W-1:0]     avg_seek_time;
    logic                          overflowed;
    logic                          no_requests;
    modport source (output valid, seek_track, is_last, total_tracks, total_seek_time,
                    avg_seek_time, overflowed, no_requests, input ready);
    modport sink   (input valid, seek_track, is_last, total_tracks, total_seek_time,
                    avg_seek_time, overflowed, no_requests, output ready);
endinterface

interface cds_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cds_pkg::FIELD_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/cds_front.sv =====
// Front end: accepts request beats, classifies them into commands and
// queues them in a two-entry FIFO for the back end. Depends on cds_pkg, cds_ifs.
module cds_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cds_req_if.sink            i_req,
    output logic               o_cmd_valid,
    output cds_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_pop
);

    cds_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    logic          push;
    cds_pkg::t_cmd cmd_in;

    assign i_req.ready = (r_fill != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Classify the incoming beat
    always_comb begin
        cmd_in.is_run     = (i_req.func == cds_pkg::FUNC_RUN);
        cmd_in.track      = i_req.track;
        cmd_in.head_track = i_req.head_track;
        cmd_in.sweep_up   = i_req.sweep_up;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_cmd_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!push && i_cmd_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ===== design/cds_back.sv =====
// Back end: sorted request store, C-LOOK sequencer, seek-time multiply and
// bit-serial average divide, result register. Depends on cds_pkg, cds_ifs.
module cds_back #(
    parameter int MAX_REQUESTS = cds_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = cds_pkg::TRACK_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  cds_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    input  logic [cds_pkg::FIELD_W-1:0] i_seek_time,
    cds_res_if.source                   o_res
);

    localparam int CW  = $clog2(MAX_REQUESTS + 1);
    localparam int IW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int W   = (TRACK_BITS > cds_pkg::FIELD_W) ? TRACK_BITS : cds_pkg::FIELD_W;
    localparam int TW  = cds_pkg::TOTAL_W;
    localparam int SW  = cds_pkg::TSEEK_W;
    localparam int DCW = $clog2(SW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;

    logic [TRACK_BITS-1:0] r_st [MAX_REQUESTS];
    logic [CW-1:0]         r_cnt;
    logic                  r_drop;
    logic [2:0]            r_state;
    logic [CW-1:0]         r_ptr;
    logic [CW-1:0]         r_step;
    logic [W-1:0]          r_head;
    logic                  r_up;
    logic [TW-1:0]         r_total;
    logic [SW-1:0]         r_prod;
    logic [SW-1:0]         r_quo;
    logic [CW-1:0]         r_rem;
    logic [DCW-1:0]        r_dcnt;
    logic [W-1:0]          r_last_trk;

    logic                  r_ovalid;
    logic [cds_pkg::FIELD_W-1:0] r_otrk;
    logic                  r_olast;
    logic [TW-1:0]         r_ototal;
    logic [SW-1:0]         r_otseek;
    logic [cds_pkg::AVG_W-1:0] r_oavg;
    logic                  r_oovf;
    logic                  r_onoreq;

    logic                  out_free;
    logic                  do_load;
    logic                  full;
    logic [TRACK_BITS-1:0] ld_trk;
    logic [W-1:0]          rd_trk;
    logic [W-1:0]          seek_dist;
    logic [TW-1:0]         n_total;
    logic [CW-1:0]         n_ptr;
    logic [CW-1:0]         start_ptr;
    logic                  scan_more;
    logic [CW:0]           rem_sh;
    logic                  rem_ge;

    assign out_free  = !r_ovalid || o_res.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign do_load   = o_cmd_pop && !i_cmd.is_run;
    assign full      = (r_cnt == CW'(MAX_REQUESTS));
    assign ld_trk    = TRACK_BITS'(i_cmd.track);

    // Sorted insertion: each cell keeps, takes the new track or takes its neighbor
    for (genvar k = 0; k < MAX_REQUESTS; k++) begin : g_cell
        logic keep;
        logic prev_le;
        assign keep = (CW'(k) < r_cnt) && (r_st[k] <= ld_trk);
        if (k == 0) begin : g_first
            assign prev_le = 1'b1;
        end else begin : g_rest
            assign prev_le = (r_st[k-1] <= ld_trk);
        end
        always_ff @(posedge i_clk) begin
            if (do_load && !full && (CW'(k) <= r_cnt) && !keep) begin
                if (k == 0) begin
                    r_st[k] <= ld_trk;
                end else begin
                    r_st[k] <= prev_le ? ld_trk : r_st[(k > 0) ? k-1 : 0];
                end
            end
        end
    end

    // Store read and head movement
    assign rd_trk    = W'(r_st[r_ptr[IW-1:0]]);
    assign seek_dist = (r_head > rd_trk) ? (r_head - rd_trk) : (rd_trk - r_head);
    assign n_total   = r_total + TW'(seek_dist);
    assign scan_more = (r_ptr < r_cnt) && (rd_trk <= r_head);

    // First entry served once the split point is known
    always_comb begin
        if (r_up) begin
            start_ptr = (r_ptr == r_cnt) ? '0 : r_ptr;
        end else begin
            start_ptr = (r_ptr == '0) ? (r_cnt - CW'(1)) : (r_ptr - CW'(1));
        end
    end

    // Walk the store circularly in the sweep direction
    always_comb begin
        if (r_up) begin
            n_ptr = (r_ptr == r_cnt - CW'(1)) ? '0 : (r_ptr + CW'(1));
        end else begin
            n_ptr = (r_ptr == '0) ? (r_cnt - CW'(1)) : (r_ptr - CW'(1));
        end
    end

    // Restoring divide step
    assign rem_sh = {r_rem, r_quo[SW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_cnt});

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.is_run) begin
                            r_state <= S_SCAN;
                        end else if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt == '0) begin
                        if (out_free) begin
                            r_drop  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else if (!scan_more) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (out_free && (r_step == r_cnt - CW'(1))) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (out_free) begin
                        r_cnt   <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Run datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ptr   <= '0;
                r_step  <= '0;
                r_total <= '0;
                r_head  <= W'(i_cmd.head_track);
                r_up    <= i_cmd.sweep_up;
            end
            S_SCAN: begin
                if (scan_more) begin
                    r_ptr <= r_ptr + CW'(1);
                end else begin
                    r_ptr <= start_ptr;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    r_total    <= n_total;
                    r_head     <= rd_trk;
                    r_last_trk <= rd_trk;
                    r_ptr      <= n_ptr;
                    r_step     <= r_step + CW'(1);
                end
            end
            S_MUL: begin
                r_prod <= SW'(r_total * i_seek_time);
                r_quo  <= SW'(r_total * i_seek_time);
                r_rem  <= '0;
                r_dcnt <= DCW'(SW);
            end
            S_DIV: begin
                r_rem  <= rem_ge ? CW'(rem_sh - {1'b0, r_cnt}) : CW'(rem_sh);
                r_quo  <= {r_quo[SW-2:0], rem_ge};
                r_dcnt <= r_dcnt - DCW'(1);
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_SCAN && r_cnt == '0 && out_free) ||
                     (r_state == S_RUN && out_free && r_step != r_cnt - CW'(1)) ||
                     (r_state == S_LAST && out_free)) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_oovf   <= r_drop;
            r_olast  <= 1'b0;
            r_onoreq <= 1'b0;
            r_ototal <= '0;
            r_otseek <= '0;
            r_oavg   <= '0;
            r_otrk   <= cds_pkg::FIELD_W'(rd_trk);
            case (r_state)
                S_SCAN: begin
                    r_otrk   <= '0;
                    r_olast  <= 1'b1;
                    r_onoreq <= 1'b1;
                end
                S_LAST: begin
                    r_otrk   <= cds_pkg::FIELD_W'(r_last_trk);
                    r_olast  <= 1'b1;
                    r_ototal <= r_total;
                    r_otseek <= r_prod;
                    r_oavg   <= cds_pkg::AVG_W'(r_quo);
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.seek_track      = r_otrk;
    assign o_res.is_last         = r_olast;
    assign o_res.total_tracks    = r_ototal;
    assign o_res.total_seek_time = r_otseek;
    assign o_res.avg_seek_time   = r_oavg;
    assign o_res.overflowed      = r_oovf;
    assign o_res.no_requests     = r_onoreq;

endmodule

// ===== design/clook_disk_scheduler.sv =====
// Top level of the C-LOOK disk scheduler: config register, front queue, back end.
// Depends on cds_pkg, cds_ifs, cds_front, cds_back.
//
// Use:
//   i_req  : request beats. func=load stores a track in a sorted store of
//            MAX_REQUESTS entries (full store: dropped, overflow flagged);
//            func=run serves the stored tracks in C-LOOK order.
//   o_res  : one result beat per served track; the last carries totals.
//            An empty run gives one beat with no_requests and is_last set.
//   i_cfg  : seek time per track, written while idle; always ready.
// Operation:
//   A two-entry queue lets the front take beats while the back end is busy.
//   A run takes a split scan, the serving of the stored tracks (one store read
//   each), a multiply, the bit-serial average divide and the last beat.
// Reset clears the store count, the overflow flag and sets seek time to 1.
// A stalled receiver holds the result register; the back end waits on it.
module clook_disk_scheduler #(
    parameter int MAX_REQUESTS = cds_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = cds_pkg::TRACK_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cds_req_if.sink    i_req,
    cds_res_if.source  o_res,
    cds_cfg_if.sink    i_cfg
);

    logic [cds_pkg::FIELD_W-1:0] r_seek_time;
    logic                        cmd_valid;
    cds_pkg::t_cmd               cmd;
    logic                        cmd_pop;

    // Config register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek_time <= cds_pkg::SEEK_RESET;
        end else if (i_cfg.valid) begin
            r_seek_time <= i_cfg.data;
        end
    end

    cds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    cds_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_seek_time (r_seek_time),
        .o_res       (o_res)
    );

    // Empty-run beat is always the final one
    a_noreq_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.no_requests |-> o_res.is_last)
        else $error("no_requests beat without is_last");

    // Totals only on the last beat
    a_totals_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.is_last |-> o_res.total_tracks == '0 &&
        o_res.total_seek_time == '0)
        else $error("totals on a non-final beat");

    // Queue never pops when empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule

// ===== tb/tb_clook_disk_scheduler.sv =====
// Self-checking testbench for the C-LOOK disk scheduler: drives load and run
// beats, predicts the served track sequence and totals, compares each result beat.
// Depends on cds_pkg, cds_ifs and the design sources.
`timescale 1ns / 100ps

module tb_clook_disk_scheduler;
    import cds_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] seek_track;
        logic               is_last;
        logic [TOTAL_W-1:0] total_tracks;
        logic [TSEEK_W-1:0] total_seek_time;
        logic [AVG_W-1:0]   avg_seek_time;
        logic               overflowed;
        logic               no_requests;
    } t_res;

    localparam int MAXQ       = MAX_REQUESTS_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cds_req_if req_if ();
    cds_res_if res_if ();
    cds_cfg_if cfg_if ();

    clook_disk_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic [FIELD_W-1:0] sorted_tracks[$];
    logic               dropped;
    logic [FIELD_W-1:0] seek_per_track;
    t_res               pending_res[$];
    int                 err_count;
    int                 idle_cycles;

    // Update the predicted store on a load, or queue the served sequence on a run
    task automatic predict_beat(input logic func, input logic [FIELD_W-1:0] trk,
                                input logic [FIELD_W-1:0] head, input logic up);
        int split;
        int pos;
        int n;
        logic [FIELD_W-1:0] seq[$];
        logic [FIELD_W-1:0] cur;
        logic [63:0] total;
        logic [63:0] tseek;
        t_res r;
        if (func == FUNC_LOAD) begin
            if (sorted_tracks.size() >= MAXQ) begin
                dropped = 1'b1;
            end else begin
                pos = sorted_tracks.size();
                while (pos > 0 && sorted_tracks[pos-1] > trk) pos--;
                sorted_tracks.insert(pos, trk);
            end
            return;
        end
        n = sorted_tracks.size();
        r = '0;
        r.overflowed = dropped;
        if (n == 0) begin
            r.is_last = 1'b1;
            r.no_requests = 1'b1;
            pending_res.push_back(r);
            dropped = 1'b0;
            return;
        end
        split = 0;
        while (split < n && sorted_tracks[split] <= head) split++;
        if (up) begin
            for (int k = split; k < n; k++) seq.push_back(sorted_tracks[k]);
            for (int k = 0; k < split; k++) seq.push_back(sorted_tracks[k]);
        end else begin
            for (int k = split; k > 0; k--) seq.push_back(sorted_tracks[k-1]);
            for (int k = n; k > split; k--) seq.push_back(sorted_tracks[k-1]);
        end
        cur = head;
        total = 0;
        foreach (seq[i]) begin
            total += (cur > seq[i]) ? cur - seq[i] : seq[i] - cur;
            cur = seq[i];
            r.seek_track = seq[i];
            if (i == n - 1) begin
                total = total & 64'h1F_FFFF;
                tseek = (total * seek_per_track) & 64'h1F_FFFF_FFFF;
                r.is_last = 1'b1;
                r.total_tracks = total[TOTAL_W-1:0];
                r.total_seek_time = tseek[TSEEK_W-1:0];
                r.avg_seek_time = 32'(tseek / n);
            end
            pending_res.push_back(r);
        end
        sorted_tracks.delete();
        dropped = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Random gap: mostly short, now and then long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int gap_mode;

    // Send one request beat; valid stays up into the next beat when no gap follows
    task automatic send_beat(input logic func, input logic [FIELD_W-1:0] trk,
                             input logic [FIELD_W-1:0] head, input logic up);
        int g;
        g = (gap_mode != 0) ? gap_len() : 0;
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.track      <= trk;
        req_if.head_track <= head;
        req_if.sweep_up   <= up;
        do @(posedge i_clk); while (!req_if.ready);
        predict_beat(func, trk, head, up);
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_seek(input logic [FIELD_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        seek_per_track = val;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result sink with random stalls
    logic stall_on;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                t_res got;
                t_res exp_r;
                got = '{res_if.seek_track, res_if.is_last, res_if.total_tracks,
                        res_if.total_seek_time, res_if.avg_seek_time,
                        res_if.overflowed, res_if.no_requests};
                if (pending_res.size() == 0) begin
                    report_mismatch("result beat with none expected");
                end else begin
                    exp_r = pending_res.pop_front();
                    if (got.seek_track !== exp_r.seek_track)
                        report_mismatch($sformatf("seek_track %0d exp %0d",
                                        got.seek_track, exp_r.seek_track));
                    if (got.is_last !== exp_r.is_last)
                        report_mismatch($sformatf("is_last %0b exp %0b",
                                        got.is_last, exp_r.is_last));
                    if (got.total_tracks !== exp_r.total_tracks)
                        report_mismatch($sformatf("total_tracks %0d exp %0d",
                                        got.total_tracks, exp_r.total_tracks));
                    if (got.total_seek_time !== exp_r.total_seek_time)
                        report_mismatch($sformatf("total_seek_time %0d exp %0d",
                                        got.total_seek_time, exp_r.total_seek_time));
                    if (got.avg_seek_time !== exp_r.avg_seek_time)
                        report_mismatch($sformatf("avg_seek_time %0d exp %0d",
                                        got.avg_seek_time, exp_r.avg_seek_time));
                    if (got.overflowed !== exp_r.overflowed)
                        report_mismatch($sformatf("overflowed %0b exp %0b",
                                        got.overflowed, exp_r.overflowed));
                    if (got.no_requests !== exp_r.no_requests)
                        report_mismatch($sformatf("no_requests %0b exp %0b",
                                        got.no_requests, exp_r.no_requests));
                end
            end
            res_if.ready <= (!stall_on || gap_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Flip between stall-heavy and stall-free stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed: extremes, both directions, empty run, head equal to a track
    task automatic test_directed();
        send_beat(FUNC_RUN, 16'h0, 16'h0, 1'b1);
        send_beat(FUNC_RUN, 16'hFFFF, 16'hFFFF, 1'b0);
        send_beat(FUNC_LOAD, 16'hFFFF, 16'h0, 1'b0);
        send_beat(FUNC_LOAD, 16'h0, 16'hFFFF, 1'b1);
        send_beat(FUNC_LOAD, 16'h8000, 16'h0, 1'b0);
        send_beat(FUNC_LOAD, 16'h8000, 16'h0, 1'b0);
        send_beat(FUNC_RUN, 16'h0, 16'h8000, 1'b1);
        send_beat(FUNC_LOAD, 16'h10, 16'h0, 1'b0);
        send_beat(FUNC_LOAD, 16'h30, 16'h0, 1'b0);
        send_beat(FUNC_LOAD, 16'h20, 16'h0, 1'b0);
        send_beat(FUNC_RUN, 16'hFFFF, 16'h20, 1'b0);
        send_beat(FUNC_LOAD, 16'hFFFF, 16'h0, 1'b0);
        send_beat(FUNC_RUN, 16'h0, 16'h0, 1'b0);
        send_beat(FUNC_LOAD, 16'h1, 16'h0, 1'b1);
        send_beat(FUNC_RUN, 16'h0, 16'hFFFF, 1'b1);
    endtask

    // Fill past capacity to hit the drop path, then run
    task automatic test_overflow();
        for (int i = 0; i < MAXQ + 3; i++)
            send_beat(FUNC_LOAD, 16'($urandom), 16'($urandom), 1'($urandom));
        send_beat(FUNC_RUN, 16'($urandom), 16'($urandom), 1'b1);
        send_beat(FUNC_RUN, 16'($urandom), 16'($urandom), 1'b0);
    endtask

    // Random load batches closed by a run; head sometimes picked from stored tracks
    task automatic test_random(input int items);
        int sent;
        int nload;
        logic [FIELD_W-1:0] head;
        sent = 0;
        while (sent < items) begin
            nload = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(0, 8);
            for (int i = 0; i < nload; i++) begin
                if ($urandom_range(0, 2) == 0)
                    send_beat(FUNC_LOAD, 16'($urandom_range(0, 15)), 16'($urandom), 1'($urandom));
                else
                    send_beat(FUNC_LOAD, 16'($urandom), 16'($urandom), 1'($urandom));
            end
            if (sorted_tracks.size() != 0 && $urandom_range(0, 2) == 0)
                head = sorted_tracks[$urandom_range(0, sorted_tracks.size() - 1)];
            else
                head = 16'($urandom);
            send_beat(FUNC_RUN, 16'($urandom), head, 1'($urandom));
            sent += nload + 1;
        end
    endtask

    initial begin
        err_count = 0;
        idle_cycles = 0;
        stall_on = 1'b1;
        gap_mode = 1;
        dropped = 1'b0;
        seek_per_track = SEEK_RESET;
        req_if.valid = 1'b0;
        req_if.func = FUNC_LOAD;
        req_if.track = '0;
        req_if.head_track = '0;
        req_if.sweep_up = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drain();
        write_seek(16'hFFFF);
        test_overflow();
        wait_drain();
        write_seek(16'h0);
        test_random(70);
        wait_drain();
        write_seek(16'($urandom));
        gap_mode = 0;
        test_random(70);
        gap_mode = 1;
        wait_drain();
        write_seek(16'hFFFF);
        test_random(70);
        wait_drain();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/cds_pkg.sv
design/cds_ifs.sv
design/cds_front.sv
design/cds_back.sv
design/clook_disk_scheduler.sv
tb/tb_clook_disk_scheduler.sv
